@@ hw/rtl/ptst_pkg.sv @@
// Package for the photon transport shell tally: item types, register codes,
// fixed-point constants and rounding helpers used by the front, engine,
// result queue and core files. No dependencies.
`default_nettype none
package ptst_pkg;

    localparam int SHELL_COUNT = 128;
    localparam int SHELL_W     = $clog2(SHELL_COUNT);
    localparam int SUM_W       = 48;
    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    localparam logic signed [32:0] ONE_Q30 = 33'sd1073741824;
    localparam logic signed [39:0] LN2_Q30 = 40'sd744261118;
    localparam logic signed [32:0] C0_Q30  = 33'sd247859072;
    localparam logic signed [32:0] C1_Q30  = -33'sd299797920;
    localparam logic signed [32:0] C2_Q30  = 33'sd356295488;
    localparam logic signed [32:0] C3_Q30  = -33'sd535700896;
    localparam logic [63:0] ONE_Q60 = 64'h1000_0000_0000_0000;

    localparam logic [15:0] ALBEDO_RST    = 16'd59578;
    localparam logic [23:0] SHELLS_RST    = 24'd595782;
    localparam logic [31:0] THRESHOLD_RST = 32'd4294967;
    localparam logic [23:0] KILL_RST      = 24'd1677722;

    typedef enum logic [1:0] {
        CFG_ALBEDO    = 2'd0,
        CFG_SHELLS    = 2'd1,
        CFG_THRESHOLD = 2'd2,
        CFG_KILL      = 2'd3
    } cfg_index_t;

    typedef enum logic [1:0] {
        PH_MOVE     = 2'd0,
        PH_ROULETTE = 2'd1,
        PH_DIR_A    = 2'd2,
        PH_DIR_B    = 2'd3
    } phase_t;

    typedef struct packed {
        logic        mode;
        logic [23:0] random_value;
        logic [6:0]  read_shell;
    } item_t;

    typedef struct packed {
        logic [1:0]  phase_done;
        logic [6:0]  shell_index;
        logic [31:0] deposit;
        logic        photon_ended;
        logic [31:0] photons_finished;
        logic [47:0] heat_sum;
        logic [47:0] heat_square_sum;
    } result_t;

    // classified entry between front and back: sample already offset by one
    typedef struct packed {
        logic        mode;
        logic [24:0] x;
        logic [6:0]  read_shell;
    } fitem_t;

    // arithmetic shift right that truncates toward zero
    function automatic logic signed [65:0] trunc_shift(input logic signed [65:0] p,
                                                       input int sh);
        logic signed [65:0] bias;
        bias = (66'sd1 <<< sh) - 66'sd1;
        return (p[65] ? (p + bias) : p) >>> sh;
    endfunction

endpackage
`default_nettype wire

@@ hw/rtl/ptst_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module ptst_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 128
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

@@ hw/rtl/ptst_front.sv @@
// Front end: accepts input items, classifies them and holds them in a
// two-entry queue for the engine. Depends on ptst_pkg.
`default_nettype none
module ptst_front (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    output logic                 full,
    input  wire ptst_pkg::item_t item,
    input  wire logic            q_pop,
    output logic                 q_valid,
    output ptst_pkg::fitem_t     q_item
);
    import ptst_pkg::*;

    fitem_t     slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       do_push;
    logic       do_pop;
    fitem_t     entry;

    assign full    = (count_reg == 2'd2);
    assign q_valid = (count_reg != 2'd0);
    assign q_item  = slot_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = q_pop && q_valid;

    always_comb
    begin
        entry.mode       = item.mode;
        entry.x          = {1'b0, item.random_value} + 25'd1;
        entry.read_shell = item.read_shell;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                slot_reg[wr_ptr_reg] <= entry;
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end
endmodule
`default_nettype wire

@@ hw/rtl/ptst_isqrt.sv @@
// Iterative 64-bit integer square root, one result bit per cycle.
// Depends on ptst_pkg only through the shared style; no package items used.
`default_nettype none
module ptst_isqrt (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [63:0] value,
    output logic             done,
    output logic [31:0]      root
);
    logic [63:0] v_reg;
    logic [63:0] res_reg;
    logic [63:0] bit_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [63:0] trial;

    assign trial = res_reg + bit_reg;
    assign done  = done_reg;
    assign root  = res_reg[31:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg    <= '0;
            res_reg  <= '0;
            bit_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            v_reg    <= value;
            res_reg  <= '0;
            bit_reg  <= 64'h1 << 62;
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            if (v_reg >= trial)
            begin
                v_reg   <= v_reg - trial;
                res_reg <= (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_reg <= res_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
            if (bit_reg[0])
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end
endmodule
`default_nettype wire

@@ hw/rtl/ptst_outbuf.sv @@
// Two-entry result queue between the engine and the result port.
// Depends on ptst_pkg.
`default_nettype none
module ptst_outbuf (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              wr,
    input  wire ptst_pkg::result_t wdata,
    output logic                   wfull,
    output logic                   empty,
    input  wire logic              pop,
    output ptst_pkg::result_t      result
);
    import ptst_pkg::*;

    result_t    slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       do_wr;
    logic       do_pop;

    assign wfull  = (count_reg == 2'd2);
    assign empty  = (count_reg == 2'd0);
    assign result = slot_reg[rd_ptr_reg];
    assign do_wr  = wr && !wfull;
    assign do_pop = pop && !empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_wr)
            begin
                slot_reg[wr_ptr_reg] <= wdata;
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            case ({do_wr, do_pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end
endmodule
`default_nettype wire

@@ hw/rtl/ptst_engine.sv @@
// Back end: sequencer with one shared multiplier that carries out move,
// roulette, direction and read items. Depends on ptst_pkg, ptst_ram, ptst_isqrt.
`default_nettype none
module ptst_engine (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_valid,
    input  wire ptst_pkg::cfg_index_t   cfg_index,
    input  wire logic [31:0]            cfg_data,
    input  wire logic                   q_valid,
    input  wire ptst_pkg::fitem_t       q_item,
    output logic                        q_pop,
    output logic                        res_wr,
    output ptst_pkg::result_t           res_data,
    input  wire logic                   res_full
);
    import ptst_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE, ST_RD, ST_RD2,
        ST_NORM, ST_MF, ST_S, ST_RA, ST_TA, ST_LR1, ST_LR2, ST_LR3, ST_LN,
        ST_PI, ST_P0, ST_P1, ST_P2, ST_Q0, ST_Q1, ST_Q2, ST_RGO, ST_RWAIT,
        ST_SH, ST_SH2, ST_DEP, ST_DSQ, ST_WR, ST_W,
        ST_ROUL, ST_D1, ST_DA, ST_DB, ST_DC, ST_DGO, ST_DWAIT, ST_DV, ST_DW,
        ST_DX, ST_OUT
    } state_t;

    state_t              state_reg;
    phase_t              phase_reg;
    logic signed [31:0]  pos_reg [3];
    logic signed [31:0]  dir_reg [3];
    logic [31:0]         weight_reg;
    logic signed [31:0]  first_reg;
    logic [31:0]         count_reg;
    logic [15:0]         albedo_reg;
    logic [23:0]         shells_reg;
    logic [31:0]         thr_reg;
    logic [23:0]         kill_reg;
    logic [SHELL_COUNT-1:0] valid_reg;

    fitem_t              item_reg;
    result_t             res_reg;
    result_t             res_init;
    logic [24:0]         norm_reg;
    logic [4:0]          p_reg;
    logic signed [32:0]  f_reg;
    logic signed [6:0]   n_reg;
    logic signed [32:0]  s_reg;
    logic signed [32:0]  ra_reg;
    logic signed [32:0]  ta_reg;
    logic signed [32:0]  lr_reg;
    logic signed [32:0]  step_reg;
    logic [63:0]         r2_reg;
    logic [SHELL_W-1:0]  shell_reg;
    logic [31:0]         dep_reg;
    logic [63:0]         aa_reg;
    logic [63:0]         t_reg;
    logic signed [65:0]  prod_reg;

    logic signed [32:0]  mul_a;
    logic signed [32:0]  mul_b;
    logic signed [65:0]  q30;
    logic signed [65:0]  q29;
    logic signed [32:0]  xi;

    logic [23:0]         norm;
    logic                norm_hi;
    logic signed [32:0]  f_cmb;
    logic signed [6:0]   n_cmb;
    logic signed [39:0]  lr2;
    logic signed [39:0]  nl;
    logic signed [39:0]  neg;
    logic signed [39:0]  pos_sum;
    logic signed [31:0]  pos_sat;
    logic [1:0]          pos_k;
    logic [25:0]         sh_raw;
    logic [SHELL_W-1:0]  sh_cmb;
    logic [31:0]         dep_cmb;
    logic [47:0]         heat_old;
    logic [47:0]         sq_old;
    logic [48:0]         heat_add;
    logic [48:0]         sq_add;
    logic [31:0]         weight_new;
    logic [35:0]         w10;
    logic [63:0]         t_cmb;
    logic                rd_in_range;

    logic                ram_we;
    logic [SHELL_W-1:0]  ram_raddr;
    logic [47:0]         heat_rdata;
    logic [47:0]         sq_rdata;
    logic [47:0]         heat_wdata;
    logic [47:0]         sq_wdata;

    logic                sq_start;
    logic [63:0]         sq_value;
    logic                sq_done;
    logic [31:0]         sq_root;

    ptst_ram #(.WIDTH(SUM_W), .DEPTH(SHELL_COUNT)) u_heat (
        .clk   (clk),
        .we    (ram_we),
        .waddr (shell_reg),
        .wdata (heat_wdata),
        .raddr (ram_raddr),
        .rdata (heat_rdata)
    );

    ptst_ram #(.WIDTH(SUM_W), .DEPTH(SHELL_COUNT)) u_heat_sq (
        .clk   (clk),
        .we    (ram_we),
        .waddr (shell_reg),
        .wdata (sq_wdata),
        .raddr (ram_raddr),
        .rdata (sq_rdata)
    );

    ptst_isqrt u_isqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sq_start),
        .value (sq_value),
        .done  (sq_done),
        .root  (sq_root)
    );

    assign q30 = trunc_shift(prod_reg, 30);
    assign q29 = trunc_shift(prod_reg, 29);
    assign xi  = $signed({1'b0, item_reg.x, 7'b0}) - ONE_Q30;

    assign q_pop    = (state_reg == ST_IDLE) && q_valid;
    assign res_wr   = (state_reg == ST_OUT);
    always_comb
    begin
        res_data = res_reg;
        res_data.photons_finished = count_reg;
    end

    // blank result for a new item; read items report phase zero
    always_comb
    begin
        res_init = '0;
        if (!q_item.mode)
        begin
            res_init.phase_done = phase_reg;
        end
    end

    assign sq_start = (state_reg == ST_RGO) || (state_reg == ST_DGO);
    assign sq_value = (state_reg == ST_DGO) ? (ONE_Q60 - t_reg) : r2_reg;

    // logarithm front: mantissa in [2/3, 4/3) and its exponent
    always_comb
    begin
        norm    = norm_reg[24:1];
        norm_hi = (norm[22:0] >= 23'h2AAAAB);
        if (norm_hi)
        begin
            f_cmb = $signed({3'b0, norm, 6'b0}) - ONE_Q30;
            n_cmb = $signed({2'b0, p_reg}) - 7'sd23;
        end
        else
        begin
            f_cmb = $signed({2'b0, norm, 7'b0}) - ONE_Q30;
            n_cmb = $signed({2'b0, p_reg}) - 7'sd24;
        end
        lr2 = q30[39:0] + {{7{f_reg[32]}}, f_reg};
        nl  = $signed({{33{n_reg[6]}}, n_reg}) * LN2_Q30;
        neg = -(nl + lr2);
    end

    // position update with saturation
    always_comb
    begin
        case (state_reg)
            ST_P0:   pos_k = 2'd0;
            ST_P1:   pos_k = 2'd1;
            default: pos_k = 2'd2;
        endcase
        pos_sum = {{8{pos_reg[pos_k][31]}}, pos_reg[pos_k]} + q30[39:0];
        if (pos_sum > 40'sh007FFFFFFF)
        begin
            pos_sat = 32'sh7FFFFFFF;
        end
        else if (pos_sum < -40'sh0080000000)
        begin
            pos_sat = -32'sh80000000;
        end
        else
        begin
            pos_sat = pos_sum[31:0];
        end
    end

    // shell, deposit, table sums, weight
    always_comb
    begin
        sh_raw = prod_reg[65:40];
        if (32'(sh_raw) > 32'(SHELL_COUNT - 1))
        begin
            sh_cmb = SHELL_W'(SHELL_COUNT - 1);
        end
        else
        begin
            sh_cmb = SHELL_W'(sh_raw);
        end
        dep_cmb    = (|prod_reg[65:47]) ? 32'hFFFFFFFF : prod_reg[46:15];
        heat_old   = valid_reg[shell_reg] ? heat_rdata : '0;
        sq_old     = valid_reg[shell_reg] ? sq_rdata : '0;
        heat_add   = {1'b0, heat_old} + {17'b0, dep_reg};
        sq_add     = {1'b0, sq_old} + {17'b0, prod_reg[63:32]};
        heat_wdata = heat_add[48] ? SUM_MAX : heat_add[47:0];
        sq_wdata   = sq_add[48] ? SUM_MAX : sq_add[47:0];
        weight_new = prod_reg[47:16];
        w10        = ({4'b0, weight_reg} << 3) + ({4'b0, weight_reg} << 1);
        t_cmb      = aa_reg + prod_reg[63:0];
        rd_in_range = (32'(item_reg.read_shell) < 32'(SHELL_COUNT));
    end

    assign ram_we = (state_reg == ST_WR);

    always_comb
    begin
        case (state_reg)
            ST_SH2:  ram_raddr = sh_cmb;
            ST_RD:   ram_raddr = SHELL_W'(item_reg.read_shell);
            default: ram_raddr = shell_reg;
        endcase
    end

    // shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_S:    begin mul_a = f_reg;  mul_b = f_reg;  end
            ST_RA:   begin mul_a = C0_Q30; mul_b = f_reg;  end
            ST_TA:   begin mul_a = C2_Q30; mul_b = f_reg;  end
            ST_LR1:  begin mul_a = ra_reg; mul_b = s_reg;  end
            ST_LR3:  begin mul_a = lr_reg; mul_b = s_reg;  end
            ST_PI:   begin mul_a = step_reg; mul_b = {dir_reg[0][31], dir_reg[0]}; end
            ST_P0:   begin mul_a = step_reg; mul_b = {dir_reg[1][31], dir_reg[1]}; end
            ST_P1:   begin mul_a = step_reg; mul_b = {dir_reg[2][31], dir_reg[2]}; end
            ST_P2:
            begin
                mul_a = {pos_reg[0][31], pos_reg[0]};
                mul_b = {pos_reg[0][31], pos_reg[0]};
            end
            ST_Q0:
            begin
                mul_a = {pos_reg[1][31], pos_reg[1]};
                mul_b = {pos_reg[1][31], pos_reg[1]};
            end
            ST_Q1:
            begin
                mul_a = {pos_reg[2][31], pos_reg[2]};
                mul_b = {pos_reg[2][31], pos_reg[2]};
            end
            ST_SH:   begin mul_a = {1'b0, sq_root}; mul_b = {9'b0, shells_reg}; end
            ST_SH2:
            begin
                mul_a = {16'b0, 17'(17'h10000 - {1'b0, albedo_reg})};
                mul_b = {1'b0, weight_reg};
            end
            ST_DSQ:  begin mul_a = {1'b0, dep_reg}; mul_b = {1'b0, dep_reg}; end
            ST_WR:   begin mul_a = {1'b0, weight_reg}; mul_b = {17'b0, albedo_reg}; end
            ST_DA:   begin mul_a = {first_reg[31], first_reg}; mul_b = {first_reg[31], first_reg}; end
            ST_DB:   begin mul_a = xi; mul_b = xi; end
            ST_DV:   begin mul_a = {first_reg[31], first_reg}; mul_b = {1'b0, sq_root}; end
            ST_DW:   begin mul_a = xi; mul_b = {1'b0, sq_root}; end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            phase_reg  <= PH_MOVE;
            for (int k = 0; k < 3; k++)
            begin
                pos_reg[k] <= '0;
            end
            dir_reg[0] <= '0;
            dir_reg[1] <= '0;
            dir_reg[2] <= ONE_Q30[31:0];
            weight_reg <= 32'h80000000;
            first_reg  <= '0;
            count_reg  <= '0;
            albedo_reg <= ALBEDO_RST;
            shells_reg <= SHELLS_RST;
            thr_reg    <= THRESHOLD_RST;
            kill_reg   <= KILL_RST;
            valid_reg  <= '0;
            item_reg   <= '0;
            res_reg    <= '0;
            norm_reg   <= '0;
            p_reg      <= '0;
            f_reg      <= '0;
            n_reg      <= '0;
            s_reg      <= '0;
            ra_reg     <= '0;
            ta_reg     <= '0;
            lr_reg     <= '0;
            step_reg   <= '0;
            r2_reg     <= '0;
            shell_reg  <= '0;
            dep_reg    <= '0;
            aa_reg     <= '0;
            t_reg      <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_ALBEDO:    albedo_reg <= cfg_data[15:0];
                    CFG_SHELLS:    shells_reg <= cfg_data[23:0];
                    CFG_THRESHOLD: thr_reg    <= cfg_data;
                    CFG_KILL:      kill_reg   <= cfg_data[23:0];
                    default:       albedo_reg <= albedo_reg;
                endcase
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (q_valid)
                    begin
                        item_reg <= q_item;
                        res_reg  <= res_init;
                        if (q_item.mode)
                        begin
                            state_reg <= ST_RD;
                        end
                        else
                        begin
                            case (phase_reg)
                                PH_MOVE:
                                begin
                                    norm_reg  <= q_item.x;
                                    p_reg     <= 5'd24;
                                    state_reg <= ST_NORM;
                                end
                                PH_ROULETTE: state_reg <= ST_ROUL;
                                PH_DIR_A:    state_reg <= ST_D1;
                                default:     state_reg <= ST_DA;
                            endcase
                        end
                    end
                end

                ST_RD:  state_reg <= ST_RD2;
                ST_RD2:
                begin
                    if (rd_in_range && valid_reg[SHELL_W'(item_reg.read_shell)])
                    begin
                        res_reg.heat_sum        <= heat_rdata;
                        res_reg.heat_square_sum <= sq_rdata;
                    end
                    state_reg <= ST_OUT;
                end

                // shift the sample up until its top bit is set
                ST_NORM:
                begin
                    if (!norm_reg[24])
                    begin
                        norm_reg <= norm_reg << 1;
                        p_reg    <= p_reg - 5'd1;
                    end
                    else
                    begin
                        state_reg <= ST_MF;
                    end
                end
                ST_MF:
                begin
                    f_reg     <= f_cmb;
                    n_reg     <= n_cmb;
                    state_reg <= ST_S;
                end
                ST_S:   state_reg <= ST_RA;
                ST_RA:
                begin
                    s_reg     <= q30[32:0];
                    state_reg <= ST_TA;
                end
                ST_TA:
                begin
                    ra_reg    <= q30[32:0] + C1_Q30;
                    state_reg <= ST_LR1;
                end
                ST_LR1:
                begin
                    ta_reg    <= q30[32:0] + C3_Q30;
                    state_reg <= ST_LR2;
                end
                ST_LR2:
                begin
                    lr_reg    <= q30[32:0] + ta_reg;
                    state_reg <= ST_LR3;
                end
                ST_LR3: state_reg <= ST_LN;
                ST_LN:
                begin
                    step_reg  <= neg[39] ? '0 : neg[38:6];
                    state_reg <= ST_PI;
                end
                ST_PI:  state_reg <= ST_P0;
                ST_P0:
                begin
                    pos_reg[0] <= pos_sat;
                    state_reg  <= ST_P1;
                end
                ST_P1:
                begin
                    pos_reg[1] <= pos_sat;
                    state_reg  <= ST_P2;
                end
                ST_P2:
                begin
                    pos_reg[2] <= pos_sat;
                    state_reg  <= ST_Q0;
                end
                ST_Q0:
                begin
                    r2_reg    <= prod_reg[63:0];
                    state_reg <= ST_Q1;
                end
                ST_Q1:
                begin
                    r2_reg    <= r2_reg + prod_reg[63:0];
                    state_reg <= ST_Q2;
                end
                ST_Q2:
                begin
                    r2_reg    <= r2_reg + prod_reg[63:0];
                    state_reg <= ST_RGO;
                end
                ST_RGO: state_reg <= ST_RWAIT;
                ST_RWAIT:
                begin
                    if (sq_done)
                    begin
                        state_reg <= ST_SH;
                    end
                end
                ST_SH:  state_reg <= ST_SH2;
                ST_SH2:
                begin
                    shell_reg <= sh_cmb;
                    res_reg.shell_index <= 7'(sh_cmb);
                    state_reg <= ST_DEP;
                end
                ST_DEP:
                begin
                    dep_reg   <= dep_cmb;
                    res_reg.deposit <= dep_cmb;
                    state_reg <= ST_DSQ;
                end
                ST_DSQ: state_reg <= ST_WR;
                ST_WR:
                begin
                    valid_reg[shell_reg] <= 1'b1;
                    state_reg <= ST_W;
                end
                ST_W:
                begin
                    weight_reg <= weight_new;
                    phase_reg  <= ({weight_new, 1'b0} < {1'b0, thr_reg}) ? PH_ROULETTE
                                                                          : PH_DIR_A;
                    state_reg  <= ST_OUT;
                end

                ST_ROUL:
                begin
                    if (item_reg.x > {1'b0, kill_reg})
                    begin
                        for (int k = 0; k < 3; k++)
                        begin
                            pos_reg[k] <= '0;
                        end
                        dir_reg[0] <= '0;
                        dir_reg[1] <= '0;
                        dir_reg[2] <= ONE_Q30[31:0];
                        weight_reg <= 32'h80000000;
                        if (count_reg != 32'hFFFFFFFF)
                        begin
                            count_reg <= count_reg + 32'd1;
                        end
                        res_reg.photon_ended <= 1'b1;
                        phase_reg <= PH_MOVE;
                    end
                    else
                    begin
                        weight_reg <= (|w10[35:32]) ? 32'hFFFFFFFF : w10[31:0];
                        phase_reg  <= PH_DIR_A;
                    end
                    state_reg <= ST_OUT;
                end

                ST_D1:
                begin
                    first_reg <= xi[31:0];
                    phase_reg <= PH_DIR_B;
                    state_reg <= ST_OUT;
                end
                ST_DA:  state_reg <= ST_DB;
                ST_DB:
                begin
                    aa_reg    <= prod_reg[63:0];
                    state_reg <= ST_DC;
                end
                ST_DC:
                begin
                    t_reg <= t_cmb;
                    // reject pairs outside the unit disc or at the origin
                    if (t_cmb > ONE_Q60 || t_cmb == 64'd0)
                    begin
                        phase_reg <= PH_DIR_A;
                        state_reg <= ST_OUT;
                    end
                    else
                    begin
                        state_reg <= ST_DGO;
                    end
                end
                ST_DGO: state_reg <= ST_DWAIT;
                ST_DWAIT:
                begin
                    if (sq_done)
                    begin
                        state_reg <= ST_DV;
                    end
                end
                ST_DV:
                begin
                    dir_reg[0] <= t_reg[60:29] - ONE_Q30[31:0];
                    state_reg  <= ST_DW;
                end
                ST_DW:
                begin
                    dir_reg[1] <= q29[31:0];
                    state_reg  <= ST_DX;
                end
                ST_DX:
                begin
                    dir_reg[2] <= q29[31:0];
                    phase_reg  <= PH_MOVE;
                    state_reg  <= ST_OUT;
                end

                ST_OUT:
                begin
                    if (!res_full)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end

                default: state_reg <= ST_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

@@ hw/rtl/photon_transport_shell_tally_core.sv @@
// Photon transport with radial shell heat tally.
//
// Input channel: push/full queue. An item is taken when push is high and full
// is low; a two-entry front queue holds items while the engine works.
// Result channel: empty/pop queue. The oldest result sits on result while
// empty is low and leaves when pop is high. A two-entry result queue lets the
// engine finish the next item while a result waits.
// Configuration: cfg_valid/cfg_ready write channel, always ready; write only
// while the block is idle.
//
// Items are carried out by the shared multiplier sequencer and the
// one-bit-per-cycle square root unit. A move normalizes the sample for the
// logarithm one bit per cycle and then takes a square root; the second
// direction step takes a square root unless its pair is rejected.
// One item is in the engine at a time.
// Reset clears the photon state, the counters and the shell tables (through
// per-shell valid bits, no clearing sweep). When pop stays low the result
// queue fills, the engine holds its finished result and the front queue fills.
`default_nettype none
module photon_transport_shell_tally_core (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    output logic                      full,
    input  wire ptst_pkg::item_t      item,
    output logic                      empty,
    input  wire logic                 pop,
    output ptst_pkg::result_t         result,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire ptst_pkg::cfg_index_t cfg_index,
    input  wire logic [31:0]          cfg_data
);
    import ptst_pkg::*;

    logic    q_valid;
    logic    q_pop;
    fitem_t  q_item;
    logic    res_wr;
    logic    res_full;
    result_t res_data;

    assign cfg_ready = 1'b1;

    ptst_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .item    (item),
        .q_pop   (q_pop),
        .q_valid (q_valid),
        .q_item  (q_item)
    );

    ptst_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .res_wr    (res_wr),
        .res_data  (res_data),
        .res_full  (res_full)
    );

    ptst_outbuf u_outbuf (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr     (res_wr),
        .wdata  (res_data),
        .wfull  (res_full),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );
endmodule
`default_nettype wire
